@@ rtl/unesc_pkg.sv @@
// Shared types, codes and helper functions for the escape sequence unescaper.
// No dependencies; imported by every module of the block.
package unesc_pkg;

    // Decoder modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [1:0] MODE_CONT   = 2'd3;

    // Status codes reported on the final result of a string
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SPECIAL     = 4'd1;
    localparam logic [3:0] ST_BARE_NL     = 4'd2;
    localparam logic [3:0] ST_BAD_ESC     = 4'd3;
    localparam logic [3:0] ST_ESC_AT_END  = 4'd4;
    localparam logic [3:0] ST_BAD_HEX     = 4'd5;
    localparam logic [3:0] ST_CODE_BIG    = 4'd6;
    localparam logic [3:0] ST_TEXT_AFTER  = 4'd7;
    localparam logic [3:0] ST_NO_MULTI    = 4'd8;
    localparam logic [3:0] ST_NON_ASCII   = 4'd9;

    // Configuration register indexes
    localparam logic [1:0] REG_COMMENT      = 2'd0;
    localparam logic [1:0] REG_SEPARATOR    = 2'd1;
    localparam logic [1:0] REG_MULTILINE    = 2'd2;
    localparam logic [1:0] REG_UTF8_ALLOWED = 2'd3;

    // Configuration reset values
    localparam logic [7:0] RST_COMMENT   = 8'd59;
    localparam logic [7:0] RST_SEPARATOR = 8'd61;

    // Character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_A_LO      = 8'h61;
    localparam logic [7:0] CH_B_LO      = 8'h62;
    localparam logic [7:0] CH_F_LO      = 8'h66;
    localparam logic [7:0] CH_N_LO      = 8'h6E;
    localparam logic [7:0] CH_R_LO      = 8'h72;
    localparam logic [7:0] CH_T_LO      = 8'h74;
    localparam logic [7:0] CH_V_LO      = 8'h76;
    localparam logic [7:0] CH_X_LO      = 8'h78;
    localparam logic [7:0] CH_X_UP      = 8'h58;

    // UTF-8 range limits
    localparam logic [23:0] CP_MAX_1B = 24'h00007F;
    localparam logic [23:0] CP_MAX_2B = 24'h0007FF;
    localparam logic [23:0] CP_MAX_3B = 24'h00FFFF;
    localparam logic [23:0] CP_MAX    = 24'h10FFFF;

    // Number of hex digits in a code point escape
    localparam logic [2:0] HEX_DIGITS = 3'd6;

    typedef struct packed {
        logic [7:0] comment_byte;
        logic [7:0] separator_byte;
        logic       multiline_enable;
        logic       utf8_allowed;
    } cfg_t;

    // Results caused by one request: bytes[0] goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;     // number of result items, 0 to 4
        logic            data;    // items carry bytes
        logic            done;    // final item ends the string
        logic [3:0]      status;
    } res_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            big;
    } enc_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // UTF-8 encode; a zero code point gives no byte
    function automatic enc_t utf8_encode(input logic [23:0] cp);
        enc_t e;
        e.bytes = '0;
        e.cnt   = 3'd0;
        e.big   = 1'b0;
        if (cp > CP_MAX) begin
            e.big = 1'b1;
        end else if (cp <= CP_MAX_1B) begin
            e.bytes[0] = cp[7:0];
            e.cnt      = (cp != 24'd0) ? 3'd1 : 3'd0;
        end else if (cp <= CP_MAX_2B) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.cnt      = 3'd2;
        end else if (cp <= CP_MAX_3B) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.cnt      = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.cnt      = 3'd4;
        end
        return e;
    endfunction

endpackage

@@ rtl/unesc_decode.sv @@
// Per-byte escape decoder: mode state, hex accumulator and sticky error.
// Depends on unesc_pkg.
module unesc_decode
    import unesc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output res_t       res
);

    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  hex_cnt_reg, hex_cnt_next;
    logic [23:0] cp_reg, cp_next;
    logic [3:0]  err_reg, err_next;

    logic [3:0][7:0] cand;
    logic [2:0]      cand_n;
    logic [3:0]      perr;
    logic [3:0]      err1;
    logic [3:0]      err_all;
    logic [2:0]      n_out;
    logic            special;
    logic            is_nl;
    logic            is_sp;
    logic            wide;
    logic [23:0]     cp_shift;
    hex_t            hx;
    enc_t            enc;

    assign special = (in_byte == CH_LBRACKET) || (in_byte == CH_RBRACKET) ||
                     (in_byte == CH_BACKSLASH) || (in_byte == CH_QUOTE) ||
                     (in_byte == CH_DQUOTE) || (in_byte == cfg.comment_byte) ||
                     (in_byte == cfg.separator_byte);
    assign is_nl    = (in_byte == CH_LF) || (in_byte == CH_CR);
    assign is_sp    = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    assign hx       = hex_value(in_byte);
    assign cp_shift = {cp_reg[19:0], hx.val};
    assign enc      = utf8_encode(cp_shift);

    // Decode one byte against the current mode
    always_comb begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        cand         = '0;
        cand_n       = 3'd0;
        perr         = ST_OK;
        case (mode_reg)
            MODE_NORMAL: begin
                if (in_byte == CH_BACKSLASH) begin
                    mode_next = MODE_ESC;
                end else if (special) begin
                    perr = ST_SPECIAL;
                end else if (is_nl && cfg.multiline_enable) begin
                    perr = ST_BARE_NL;
                end else begin
                    cand[0] = in_byte;
                    cand_n  = 3'd1;
                end
            end
            MODE_ESC: begin
                mode_next = MODE_NORMAL;
                cand_n    = 3'd1;
                // Reserved bytes stand for themselves ahead of any other meaning
                if (in_byte == cfg.comment_byte || in_byte == cfg.separator_byte) begin
                    cand[0] = in_byte;
                end else begin
                    case (in_byte)
                        CH_A_LO: cand[0] = CH_BEL;
                        CH_B_LO: cand[0] = CH_BS;
                        CH_F_LO: cand[0] = CH_FF;
                        CH_N_LO: cand[0] = CH_LF;
                        CH_R_LO: cand[0] = CH_CR;
                        CH_T_LO: cand[0] = CH_TAB;
                        CH_V_LO: cand[0] = CH_VT;
                        CH_LBRACKET, CH_RBRACKET, CH_QUOTE, CH_DQUOTE, CH_BACKSLASH: begin
                            cand[0] = in_byte;
                        end
                        CH_X_LO, CH_X_UP: begin
                            cand_n       = 3'd0;
                            mode_next    = MODE_HEX;
                            hex_cnt_next = 3'd0;
                            cp_next      = 24'd0;
                        end
                        CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                            if (!cfg.multiline_enable) begin
                                cand_n = 3'd0;
                                perr   = ST_NO_MULTI;
                            end else if (is_nl) begin
                                cand[0] = CH_LF;
                            end else begin
                                cand_n    = 3'd0;
                                mode_next = MODE_CONT;
                            end
                        end
                        default: begin
                            cand_n = 3'd0;
                            perr   = ST_BAD_ESC;
                        end
                    endcase
                end
            end
            MODE_HEX: begin
                if (!hx.ok) begin
                    perr = ST_BAD_HEX;
                end else begin
                    cp_next      = cp_shift;
                    hex_cnt_next = hex_cnt_reg + 3'd1;
                    if (hex_cnt_next >= HEX_DIGITS) begin
                        mode_next = MODE_NORMAL;
                        if (enc.big) begin
                            perr = ST_CODE_BIG;
                        end else begin
                            cand   = enc.bytes;
                            cand_n = enc.cnt;
                        end
                    end
                end
            end
            default: begin
                // Continuation: only spacing up to the newline
                if (is_sp) begin
                    mode_next = MODE_CONT;
                end else if (is_nl) begin
                    mode_next = MODE_NORMAL;
                    cand[0]   = CH_LF;
                    cand_n    = 3'd1;
                end else begin
                    perr = ST_TEXT_AFTER;
                end
            end
        endcase
    end

    // Flag bytes above 127 when UTF-8 output is off
    always_comb begin
        wide = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < cand_n && cand[i][7]) begin
                wide = 1'b1;
            end
        end
    end

    // Merge errors, close the string on the final byte
    always_comb begin
        logic [3:0][7:0] outb;
        logic [2:0]      outn;
        outb = cand;
        outn = cand_n;
        if (perr != ST_OK) begin
            err1 = perr;
        end else if (!cfg.utf8_allowed && wide) begin
            err1 = ST_NON_ASCII;
        end else begin
            err1 = ST_OK;
        end
        if (is_last && err1 == ST_OK) begin
            case (mode_next)
                MODE_ESC:  err1 = ST_ESC_AT_END;
                MODE_HEX:  err1 = ST_BAD_HEX;
                MODE_CONT: begin
                    // Continuation mode never leaves a byte from this request
                    outb[0] = CH_LF;
                    outn    = 3'd1;
                end
                default: ;
            endcase
        end
        err_all = (err_reg != ST_OK) ? err_reg : err1;
        n_out   = (err_all != ST_OK) ? 3'd0 : outn;

        res.bytes  = outb;
        res.data   = (n_out != 3'd0);
        res.done   = is_last;
        res.status = is_last ? err_all : ST_OK;
        if (is_last && n_out == 3'd0) begin
            res.bytes = '0;
            res.cnt   = 3'd1;
        end else begin
            res.cnt   = n_out;
        end
    end

    // Advance state; a pending error freezes it until the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_NORMAL;
            hex_cnt_reg <= 3'd0;
            cp_reg      <= 24'd0;
            err_reg     <= ST_OK;
        end else if (accept) begin
            if (is_last) begin
                mode_reg    <= MODE_NORMAL;
                hex_cnt_reg <= 3'd0;
                cp_reg      <= 24'd0;
                err_reg     <= ST_OK;
            end else if (err_reg == ST_OK) begin
                mode_reg    <= mode_next;
                hex_cnt_reg <= hex_cnt_next;
                cp_reg      <= cp_next;
                err_reg     <= err_next;
            end
        end
    end

    assign err_next = err_all;

endmodule

@@ rtl/unesc_outbuf.sv @@
// Result register: holds the results of one request and hands them out
// one per cycle while m_ready is high. Depends on unesc_pkg.
module unesc_outbuf
    import unesc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  res_t       res,
    output logic       load_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_done_res,
    output logic [3:0] m_status
);

    logic [3:0][7:0] bytes_reg;
    logic [2:0]      left_reg;
    logic            data_reg;
    logic            done_reg;
    logic [3:0]      status_reg;
    logic            final_item;

    assign m_valid    = (left_reg != 3'd0);
    assign final_item = (left_reg == 3'd1);
    assign load_ready = !m_valid || (m_ready && final_item);

    assign m_out_byte   = data_reg ? bytes_reg[0] : 8'd0;
    assign m_byte_valid = data_reg;
    assign m_done_res   = done_reg && final_item;
    assign m_status     = (done_reg && final_item) ? status_reg : ST_OK;

    // Item count is control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= 3'd0;
        end else if (load) begin
            left_reg <= res.cnt;
        end else if (m_valid && m_ready) begin
            left_reg <= left_reg - 3'd1;
        end
    end

    // Load a new result set or shift the next byte to the front
    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg  <= res.bytes;
            data_reg   <= res.data;
            done_reg   <= res.done;
            status_reg <= res.status;
        end else if (m_valid && m_ready) begin
            bytes_reg  <= {8'd0, bytes_reg[3:1]};
        end
    end

endmodule

@@ rtl/escape_sequence_unescaper.sv @@
// Top level of the escape sequence unescaper: configuration registers,
// byte decoder and result register. Depends on unesc_pkg, unesc_decode, unesc_outbuf.
//
// Usage:
//   Raw bytes of one value string enter on the s_ channel, s_is_last set on
//   the final byte. Unescaped bytes leave on the m_ channel, one per handshake.
//   A raw byte causes zero to four results (a hex escape gives up to four
//   UTF-8 bytes). The final byte always causes at least one result, and its
//   last result carries m_done_res and m_status; a result with
//   m_byte_valid low carries only the status.
//   A result appears in the cycle after its raw byte is taken.
//   Throughput: one raw byte per cycle while each causes at most one result and
//   m_ready is high; a byte causing more results holds the input until the
//   single result register, draining one item per cycle, hands out its last.
//   When m_ready is low the result register holds and s_ready drops once the
//   results of the previous byte are not all taken.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wr_data
//   while idle. Reset restores the register defaults (comment 59, equals 61,
//   multiline on, UTF-8 allowed) and empties the result register.
module escape_sequence_unescaper
    import unesc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_done_res,
    output logic [3:0] m_status,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wr_data
);

    cfg_t cfg_reg;
    res_t res;
    logic accept;

    assign accept = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.comment_byte     <= RST_COMMENT;
            cfg_reg.separator_byte   <= RST_SEPARATOR;
            cfg_reg.multiline_enable <= 1'b1;
            cfg_reg.utf8_allowed     <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COMMENT:      cfg_reg.comment_byte     <= cfg_wr_data;
                REG_SEPARATOR:    cfg_reg.separator_byte   <= cfg_wr_data;
                REG_MULTILINE:    cfg_reg.multiline_enable <= cfg_wr_data[0];
                REG_UTF8_ALLOWED: cfg_reg.utf8_allowed     <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    unesc_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (accept),
        .in_byte (s_in_byte),
        .is_last (s_is_last),
        .res     (res)
    );

    unesc_outbuf u_outbuf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept),
        .res          (res),
        .load_ready   (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_done_res   (m_done_res),
        .m_status     (m_status)
    );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for escape_sequence_unescaper: random and directed value strings,
// an in-bench unescape predictor and a result checker. Depends on unesc_pkg and the RTL.
module tb;
    import unesc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } raw_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       done;
        logic [3:0] status;
    } unesc_result_t;

    // Characters used to build stimulus that the package does not name
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_Q_LO = 8'h71;

    localparam logic [7:0] ESC_LETTERS [12] = '{CH_A_LO, CH_B_LO, CH_F_LO, CH_N_LO, CH_R_LO,
        CH_T_LO, CH_V_LO, CH_LBRACKET, CH_RBRACKET, CH_QUOTE, CH_DQUOTE, CH_BACKSLASH};
    localparam logic [23:0] CP_LIMITS [8] = '{24'h00007F, 24'h000080, 24'h0007FF, 24'h000800,
        24'h00FFFF, 24'h010000, 24'h10FFFF, 24'h110000};

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'd0;
    logic       s_is_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_done_res;
    logic [3:0] m_status;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = REG_COMMENT;
    logic [7:0] cfg_wr_data = 8'd0;

    escape_sequence_unescaper dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_done_res   (m_done_res),
        .m_status     (m_status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    raw_req_t      pending_req[$];
    unesc_result_t unescaped_q[$];
    logic [7:0]    text_q[$];

    bit req_taken = 1'b0;
    bit idle_on = 1'b1;
    int gap_left = 0;
    int stall_left = 0;
    int mismatch_cnt = 0;
    int result_cnt = 0;
    int fed_cnt = 0;
    int str_cnt = 0;
    int err_str_cnt = 0;
    int setting_cnt = 1;

    // Predictor state and its copy of the registers
    cfg_t        cfg_now;
    logic [1:0]  dec_mode = MODE_NORMAL;
    logic [2:0]  hex_cnt = 3'd0;
    logic [23:0] hex_acc = 24'd0;
    logic [3:0]  err_code = ST_OK;
    logic [7:0]  out_bytes [4];
    int          out_cnt = 0;

    function automatic bit is_reserved(input logic [7:0] c);
        return c == CH_LBRACKET || c == CH_RBRACKET || c == CH_BACKSLASH || c == CH_QUOTE ||
               c == CH_DQUOTE || c == cfg_now.comment_byte || c == cfg_now.separator_byte;
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= CH_ZERO && c < CH_ZERO + 8'd10) return {1'b1, 4'(c - CH_ZERO)};
        if (c >= CH_A_UP && c < CH_A_UP + 8'd6) return {1'b1, 4'(c - CH_A_UP + 8'd10)};
        if (c >= CH_A_LO && c < CH_A_LO + 8'd6) return {1'b1, 4'(c - CH_A_LO + 8'd10)};
        return 5'd0;
    endfunction

    task automatic flag_error(input logic [3:0] code);
        if (err_code == ST_OK) err_code = code;
    endtask

    task automatic push_out(input logic [7:0] c);
        if (!cfg_now.utf8_allowed && c[7]) begin
            flag_error(ST_NON_ASCII);
        end else if (out_cnt < 4) begin
            out_bytes[out_cnt] = c;
            out_cnt++;
        end
    endtask

    // UTF-8 encode one code point, dropping a zero
    task automatic push_code_point(input logic [23:0] cp);
        if (cp > CP_MAX) begin
            flag_error(ST_CODE_BIG);
        end else if (cp <= CP_MAX_1B) begin
            if (cp != 24'd0) push_out(cp[7:0]);
        end else if (cp <= CP_MAX_2B) begin
            push_out({3'b110, cp[10:6]});
            push_out({2'b10, cp[5:0]});
        end else if (cp <= CP_MAX_3B) begin
            push_out({4'b1110, cp[15:12]});
            push_out({2'b10, cp[11:6]});
            push_out({2'b10, cp[5:0]});
        end else begin
            push_out({5'b11110, cp[20:18]});
            push_out({2'b10, cp[17:12]});
            push_out({2'b10, cp[11:6]});
            push_out({2'b10, cp[5:0]});
        end
    endtask

    task automatic take_escape(input logic [7:0] c);
        dec_mode = MODE_NORMAL;
        // Reserved bytes always stand for themselves
        if (c == cfg_now.comment_byte || c == cfg_now.separator_byte) begin
            push_out(c);
        end else begin
            case (c)
                CH_A_LO: push_out(CH_BEL);
                CH_B_LO: push_out(CH_BS);
                CH_F_LO: push_out(CH_FF);
                CH_N_LO: push_out(CH_LF);
                CH_R_LO: push_out(CH_CR);
                CH_T_LO: push_out(CH_TAB);
                CH_V_LO: push_out(CH_VT);
                CH_LBRACKET, CH_RBRACKET, CH_QUOTE, CH_DQUOTE, CH_BACKSLASH: push_out(c);
                CH_X_LO, CH_X_UP: begin
                    dec_mode = MODE_HEX;
                    hex_cnt = 3'd0;
                    hex_acc = 24'd0;
                end
                CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                    if (!cfg_now.multiline_enable) flag_error(ST_NO_MULTI);
                    else if (c == CH_LF || c == CH_CR) push_out(CH_LF);
                    else dec_mode = MODE_CONT;
                end
                default: flag_error(ST_BAD_ESC);
            endcase
        end
    endtask

    task automatic decode_step(input logic [7:0] c);
        logic [4:0] dig;
        case (dec_mode)
            MODE_NORMAL: begin
                if (c == CH_BACKSLASH) dec_mode = MODE_ESC;
                else if (is_reserved(c)) flag_error(ST_SPECIAL);
                else if ((c == CH_LF || c == CH_CR) && cfg_now.multiline_enable)
                    flag_error(ST_BARE_NL);
                else push_out(c);
            end
            MODE_ESC: take_escape(c);
            MODE_HEX: begin
                dig = digit_of(c);
                if (!dig[4]) begin
                    flag_error(ST_BAD_HEX);
                end else begin
                    hex_acc = {hex_acc[19:0], dig[3:0]};
                    hex_cnt++;
                    if (hex_cnt >= HEX_DIGITS) begin
                        dec_mode = MODE_NORMAL;
                        push_code_point(hex_acc);
                    end
                end
            end
            default: begin
                // Inside a continuation only spacing may come before the line end
                if (c == CH_LF || c == CH_CR) begin
                    dec_mode = MODE_NORMAL;
                    push_out(CH_LF);
                end else if (c != CH_SPACE && c != CH_TAB) begin
                    flag_error(ST_TEXT_AFTER);
                end
            end
        endcase
    endtask

    // Work out the results of one accepted request and queue them
    task automatic unescape_byte(input logic [7:0] c, input logic last);
        unesc_result_t res;
        int k;
        out_cnt = 0;
        if (err_code == ST_OK) begin
            decode_step(c);
            if (last && err_code == ST_OK) begin
                case (dec_mode)
                    MODE_ESC:  flag_error(ST_ESC_AT_END);
                    MODE_HEX:  flag_error(ST_BAD_HEX);
                    MODE_CONT: push_out(CH_LF);
                    default:   ;
                endcase
            end
        end
        if (err_code != ST_OK) out_cnt = 0;
        for (k = 0; k < out_cnt; k++) begin
            res = '{data: out_bytes[k], has_data: 1'b1, done: 1'b0, status: ST_OK};
            if (last && k == out_cnt - 1) begin
                res.done = 1'b1;
                res.status = err_code;
            end
            unescaped_q.push_back(res);
        end
        if (last) begin
            if (out_cnt == 0)
                unescaped_q.push_back('{data: 8'd0, has_data: 1'b0, done: 1'b1,
                                        status: err_code});
            if (err_code != ST_OK) err_str_cnt++;
            dec_mode = MODE_NORMAL;
            hex_cnt = 3'd0;
            hex_acc = 24'd0;
            err_code = ST_OK;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sample the request handshake and predict
    always @(posedge aclk) begin
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) unescape_byte(s_in_byte, s_is_last);
    end

    // Request driver: hold until taken, then advance after a random gap when idle_on is set
    always @(negedge aclk) begin : req_drive
        raw_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
                nxt = pending_req.pop_front();
                s_valid <= 1'b1;
                s_in_byte <= nxt.data;
                s_is_last <= nxt.last;
                gap_left <= idle_on ? pick_gap() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_on) stall_left <= pick_gap();
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Result monitor: compare against the oldest expectation
    always @(posedge aclk) begin : result_mon
        unesc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_cnt++;
            if (unescaped_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h/%b/%b/%0d",
                         $time, m_out_byte, m_byte_valid, m_done_res, m_status);
                mismatch_cnt++;
            end else begin
                want = unescaped_q.pop_front();
                check_field("out_byte", want.data, m_out_byte);
                check_field("byte_valid", want.has_data, m_byte_valid);
                check_field("done_res", want.done, m_done_res);
                check_field("status", want.status, m_status);
            end
        end
    end

    // Stimulus construction
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return CH_ZERO + 8'(nib);
        return ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] safe_char();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        while (is_reserved(c)) c = 8'($urandom_range(32, 126));
        return c;
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(0, 1) ? CH_LF : CH_CR;
    endfunction

    task automatic add_hex_text(input logic [23:0] cp, input int ndig);
        int i;
        for (i = ndig - 1; i >= 0; i--) text_q.push_back(hex_char(cp[i*4 +: 4]));
    endtask

    task automatic add_hex_escape(input bit clean);
        int kind;
        logic [23:0] cp;
        kind = $urandom_range(0, 7);
        if (clean) kind = cfg_now.utf8_allowed ? (kind == 5 ? 0 : kind) : (kind[0] ? 0 : 4);
        case (kind)
            0: cp = 24'($urandom_range(1, 'h7F));
            1: cp = 24'($urandom_range('h80, 'h7FF));
            2: cp = 24'($urandom_range('h800, 'hFFFF));
            3: cp = 24'($urandom_range('h10000, 'h10FFFF));
            4: cp = 24'd0;
            5: cp = 24'($urandom_range('h110000, 'hFFFFFF));
            6: cp = 24'($urandom_range('hD800, 'hDFFF));
            default: cp = CP_LIMITS[$urandom_range(0, 7)];
        endcase
        text_q.push_back(CH_BACKSLASH);
        text_q.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
        add_hex_text(cp, 6);
    endtask

    task automatic add_token(input bit clean);
        int r;
        int i;
        logic [7:0] c;
        r = clean ? $urandom_range(0, 79) : $urandom_range(0, 99);
        if (r < 35) begin
            text_q.push_back(safe_char());
        end else if (r < 45) begin
            if (clean && !cfg_now.utf8_allowed) text_q.push_back(safe_char());
            else text_q.push_back(8'($urandom_range(128, 255)));
        end else if (r < 60) begin
            text_q.push_back(CH_BACKSLASH);
            i = $urandom_range(0, 13);
            if (i == 12) text_q.push_back(cfg_now.comment_byte);
            else if (i == 13) text_q.push_back(cfg_now.separator_byte);
            else text_q.push_back(ESC_LETTERS[i]);
        end else if (r < 72) begin
            add_hex_escape(clean);
        end else if (r < 80) begin
            // Line continuation; bare line end in a clean string when continuation is not allowed
            if (clean && !cfg_now.multiline_enable) begin
                text_q.push_back(line_end());
            end else begin
                text_q.push_back(CH_BACKSLASH);
                case ($urandom_range(0, 3))
                    0: c = CH_SPACE;
                    1: c = CH_TAB;
                    2: c = CH_LF;
                    default: c = CH_CR;
                endcase
                text_q.push_back(c);
                if (c == CH_SPACE || c == CH_TAB) begin
                    for (i = $urandom_range(0, 3); i > 0; i--)
                        text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                    if (clean || $urandom_range(0, 2) != 0) text_q.push_back(line_end());
                end
            end
        end else if (r < 85) begin
            text_q.push_back(line_end());
        end else if (r < 90) begin
            case ($urandom_range(0, 5))
                0: text_q.push_back(CH_LBRACKET);
                1: text_q.push_back(CH_RBRACKET);
                2: text_q.push_back(CH_QUOTE);
                3: text_q.push_back(CH_DQUOTE);
                4: text_q.push_back(cfg_now.comment_byte);
                default: text_q.push_back(cfg_now.separator_byte);
            endcase
        end else if (r < 94) begin
            text_q.push_back(CH_BACKSLASH);
            text_q.push_back(8'($urandom_range(0, 255)));
        end else if (r < 97) begin
            // Hex escape broken by a non-digit
            text_q.push_back(CH_BACKSLASH);
            text_q.push_back(CH_X_LO);
            add_hex_text(24'($urandom), $urandom_range(0, 5));
            c = 8'($urandom_range(0, 255));
            while (digit_of(c) >= 5'd16) c = 8'($urandom_range(0, 255));
            text_q.push_back(c);
        end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic flush_text();
        int i;
        for (i = 0; i < text_q.size(); i++)
            pending_req.push_back('{data: text_q[i], last: i == text_q.size() - 1});
        fed_cnt += text_q.size();
        str_cnt++;
        text_q.delete();
    endtask

    task automatic queue_string(input bit clean);
        int ntok;
        int r;
        text_q.delete();
        for (ntok = $urandom_range(1, 6); ntok > 0; ntok--) add_token(clean);
        // Leave an escape open at the end now and then
        if (!clean) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                text_q.push_back(CH_BACKSLASH);
            end else if (r < 14) begin
                text_q.push_back(CH_BACKSLASH);
                text_q.push_back(CH_X_UP);
                add_hex_text(24'($urandom), $urandom_range(0, 5));
            end
        end
        flush_text();
    endtask

    task automatic queue_random(input int count);
        int target;
        target = fed_cnt + count;
        while (fed_cnt < target) queue_string($urandom_range(0, 9) < 7);
    endtask

    task automatic wait_idle();
        while (pending_req.size() != 0 || s_valid || unescaped_q.size() != 0)
            @(negedge aclk);
    endtask

    // Program all registers once the block has drained
    task automatic program_regs(input logic [7:0] cmt, input logic [7:0] sep,
                                input logic ml, input logic utf);
        wait_idle();
        repeat (4) @(negedge aclk);
        cfg_now = '{comment_byte: cmt, separator_byte: sep, multiline_enable: ml,
                    utf8_allowed: utf};
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_COMMENT;
        cfg_wr_data <= cmt;
        @(negedge aclk);
        cfg_index <= REG_SEPARATOR;
        cfg_wr_data <= sep;
        @(negedge aclk);
        cfg_index <= REG_MULTILINE;
        cfg_wr_data <= {7'($urandom), ml};
        @(negedge aclk);
        cfg_index <= REG_UTF8_ALLOWED;
        cfg_wr_data <= {7'($urandom), utf};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        setting_cnt++;
    endtask

    initial begin
        cfg_now = '{comment_byte: RST_COMMENT, separator_byte: RST_SEPARATOR,
                    multiline_enable: 1'b1, utf8_allowed: 1'b1};
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed strings under the reset settings
        text_q = '{8'hFF};
        flush_text();
        text_q = '{CH_BACKSLASH, RST_COMMENT, CH_BACKSLASH, RST_SEPARATOR};
        flush_text();
        text_q = '{CH_BACKSLASH, CH_X_LO};
        add_hex_text(CP_MAX, 6);
        flush_text();
        text_q = '{CH_BACKSLASH};
        flush_text();
        text_q = '{CH_BACKSLASH, CH_SPACE};
        flush_text();
        text_q = '{CH_LBRACKET};
        flush_text();
        text_q = '{CH_BACKSLASH, CH_Q_LO};
        flush_text();
        text_q = '{CH_BACKSLASH, CH_X_LO, CH_ZERO + 8'd1, CH_ZERO + 8'd2};
        flush_text();
        queue_random(40);

        program_regs(8'd0, 8'd255, 1'b0, 1'b0);
        queue_random(40);
        program_regs(8'd255, 8'd0, 1'b1, 1'b0);
        queue_random(40);
        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 1'b1);
        queue_random(40);
        // No idling at all in this setting
        idle_on = 1'b0;
        program_regs(CH_DQUOTE ^ 8'h01, CH_RBRACKET ^ 8'h67, 1'b1, 1'b1);
        queue_random(40);
        idle_on = 1'b1;
        // Reserved bytes that collide with escape letters and the backslash
        program_regs(CH_N_LO, CH_BACKSLASH, 1'b1, 1'b1);
        queue_random(40);

        wait_idle();
        repeat (8) @(negedge aclk);
        $display("Fed %0d raw bytes in %0d strings over %0d register settings.",
                 fed_cnt, str_cnt, setting_cnt);
        $display("Checked %0d results; %0d strings ended with an error status.",
                 result_cnt, err_str_cnt);
        if (mismatch_cnt == 0 && unescaped_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding.", unescaped_q.size());
        $display("tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/unesc_pkg.sv
rtl/unesc_decode.sv
rtl/unesc_outbuf.sv
rtl/escape_sequence_unescaper.sv
tb/sv/tb.sv
